/* design/pas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_pkg
// Shared constants, types and build-time tables of the allpass phaser.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int MAX_STAGES      = 8;
    localparam int SAMPLE_RATE     = 48000;
    localparam int COEF_TABLE_BITS = 10;

    localparam int TBL_SIZE  = 1 << COEF_TABLE_BITS;
    localparam int QUARTER   = 1 << (COEF_TABLE_BITS - 2);
    localparam int STAGE_W   = $clog2(MAX_STAGES);
    localparam int CNT_W     = $clog2(MAX_STAGES + 1);

    localparam int SMP_W     = 24;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DEPTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd4;

    localparam logic [19:0] RST_PHASE_STEP    = 20'd89478;
    localparam logic [16:0] RST_SWEEP_DEPTH   = 17'd65536;
    localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd0;
    localparam logic [3:0]  RST_STAGE_COUNT   = 4'd4;
    localparam logic [16:0] RST_WET_MIX       = 17'd32768;

    localparam logic [16:0] UNITY_Q16   = 17'd65536;
    localparam logic [15:0] FB_MAX      = 16'd58982;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = PI_Q30 >>> 1;
    localparam longint LN2_Q30     = 64'sd744261118;

    typedef struct packed {
        logic [19:0]      phase_step;
        logic [16:0]      depth;
        logic [15:0]      fb;
        logic [CNT_W-1:0] stages;
        logic [16:0]      mix;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [SMP_W-1:0] sample;
    } item_t;

    typedef logic [TBL_SIZE-1:0][16:0] lfo_tab_t;
    typedef logic [TBL_SIZE:0][17:0]   coef_tab_t;

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(8388607);
        lo = -ACC_W'(8388608);
        if (v > hi)
            return SMP_W'(8388607);
        else if (v < lo)
            return SMP_W'(-8388608);
        else
            return v[SMP_W-1:0];
    endfunction

    // truncating signed quotient by shift and subtract, table build only
    function automatic longint cdiv(input longint num, input longint dvs);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        logic [64:0] r;
        logic        neg;
        neg = (num < 0) != (dvs < 0);
        un = (num < 0) ? 64'(-num) : 64'(num);
        ud = (dvs < 0) ? 64'(-dvs) : 64'(dvs);
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], un[b]};
            if (r >= {1'b0, ud})
            begin
                r = r - {1'b0, ud};
                q[b] = 1'b1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sin_q30(input longint xin);
        longint x;
        longint x2;
        longint term;
        longint sum;
        x = xin;
        if (x < 0)
            x = 0;
        if (x > HALF_PI_Q30)
            x = HALF_PI_Q30;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int k = 0; k < 6; k++)
        begin
            term = cdiv((term * x2) >>> 30, longint'((2 * k + 2) * (2 * k + 3)));
            if ((k & 1) == 1)
                sum = sum + term;
            else
                sum = sum - term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        return sum;
    endfunction

    function automatic lfo_tab_t build_lfo();
        lfo_tab_t t;
        longint q;
        longint r;
        longint j;
        longint ang;
        longint mag;
        for (int i = 0; i < TBL_SIZE; i++)
        begin
            q = longint'(i >> (COEF_TABLE_BITS - 2));
            r = longint'(i & (QUARTER - 1));
            j = ((q & 1) == 1) ? longint'(QUARTER) - r : r;
            ang = (j * PI_Q30 * 2) >>> COEF_TABLE_BITS;
            mag = (sin_q30(ang) + 16384) >>> 15;
            if (q < 2)
                t[i] = 17'(32768 + mag);
            else
                t[i] = 17'(32768 - mag);
        end
        return t;
    endfunction

    function automatic coef_tab_t build_coef();
        coef_tab_t t;
        longint e;
        longint ip;
        longint fr;
        longint y;
        longint term;
        longint sum;
        longint fc;
        longint ratio;
        longint theta;
        longint s;
        longint c;
        longint den;
        for (int i = 0; i <= TBL_SIZE; i++)
        begin
            e = longint'(3 * i);
            ip = e >>> COEF_TABLE_BITS;
            fr = e & longint'(TBL_SIZE - 1);
            y = (fr * LN2_Q30) >>> COEF_TABLE_BITS;
            term = Q30_ONE;
            sum = Q30_ONE;
            for (int n = 1; n <= 10; n++)
            begin
                term = cdiv((term * y) >>> 30, longint'(n));
                sum = sum + term;
            end
            fc = 200 * (sum <<< ip);
            ratio = cdiv(fc, longint'(SAMPLE_RATE));
            theta = (ratio * PI_Q30) >>> 30;
            if (theta > HALF_PI_Q30)
                theta = HALF_PI_Q30;
            s = sin_q30(theta);
            c = sin_q30(HALF_PI_Q30 - theta);
            den = s + c;
            if (den == 0)
                den = 1;
            t[i] = 18'(cdiv((s - c) * 65536, den));
        end
        return t;
    endfunction

    localparam lfo_tab_t  LFO_TABLE  = build_lfo();
    localparam coef_tab_t COEF_TABLE = build_coef();

endpackage

/* design/phaser_allpass_sweep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phaser_allpass_sweep
// Digital phaser: lfo swept first-order allpass cascade with feedback and
// dry/wet mix, Q1.23 samples.
// ----------------------------------------------------------------------------
//  channel   signals                        width
//  input     in_valid, in_stall, sample_in  24 signed
//  output    out_valid, out_stall, sample_out 24 signed
//  config    cfg_we, cfg_index, cfg_data    3 / 20
//
//  one sample at a time runs through the back sequencer, which takes the
//  next only when idle, using the single shared multiplier throughout
//  a two-entry queue takes samples while the back end works or is stalled
//  the output register holds a result until its transfer
//  reset clears lfo phase, feedback and stage history and loads register defaults
module phaser_allpass_sweep
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [pas_pkg::SMP_W-1:0] sample_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [pas_pkg::SMP_W-1:0] sample_out
);
    import pas_pkg::*;

    item_t item;
    cfg_t  cfg;
    logic  pop;

    pas_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .pop       (pop),
        .item      (item),
        .cfg       (cfg)
    );

    pas_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

/* design/pas_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_front
// Input side: config registers with clamping and a two-entry sample queue.
// ----------------------------------------------------------------------------
module pas_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [pas_pkg::SMP_W-1:0] sample_in,
    input  logic                             pop,
    output pas_pkg::item_t                   item,
    output pas_pkg::cfg_t                    cfg
);
    import pas_pkg::*;

    logic [19:0]             phase_step_reg;
    logic [16:0]             depth_reg;
    logic [15:0]             fb_reg;
    logic [3:0]              stages_reg;
    logic [16:0]             mix_reg;

    logic signed [SMP_W-1:0] q_reg [2];
    logic                    wr_ptr_reg;
    logic                    rd_ptr_reg;
    logic [1:0]              count_reg;
    logic                    push;
    logic                    do_pop;
    logic [3:0]              st_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= RST_PHASE_STEP;
            depth_reg      <= RST_SWEEP_DEPTH;
            fb_reg         <= RST_FEEDBACK_GAIN;
            stages_reg     <= RST_STAGE_COUNT;
            mix_reg        <= RST_WET_MIX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PHASE_STEP:    phase_step_reg <= cfg_data[19:0];
                REG_SWEEP_DEPTH:   depth_reg      <= cfg_data[16:0];
                REG_FEEDBACK_GAIN: fb_reg         <= cfg_data[15:0];
                REG_STAGE_COUNT:   stages_reg     <= cfg_data[3:0];
                REG_WET_MIX:       mix_reg        <= cfg_data[16:0];
                default:           ;
            endcase
        end
    end

    // clamp stage count, then force even
    always_comb
    begin
        if (stages_reg < 4'd2)
            st_clamp = 4'd2;
        else if (32'(stages_reg) > MAX_STAGES)
            st_clamp = 4'(MAX_STAGES);
        else
            st_clamp = stages_reg;
        st_clamp[0] = 1'b0;
    end

    assign cfg.phase_step = phase_step_reg;
    assign cfg.depth      = (depth_reg > UNITY_Q16) ? UNITY_Q16 : depth_reg;
    assign cfg.fb         = (fb_reg > FB_MAX) ? FB_MAX : fb_reg;
    assign cfg.stages     = CNT_W'(st_clamp);
    assign cfg.mix        = (mix_reg > UNITY_Q16) ? UNITY_Q16 : mix_reg;

    assign in_stall    = (count_reg == 2'd2);
    assign push        = in_valid && !in_stall;
    assign do_pop      = pop && (count_reg != 2'd0);
    assign item.valid  = (count_reg != 2'd0);
    assign item.sample = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= sample_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(do_pop);
        end
    end

endmodule

/* design/pas_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_back
// Sample sequencer: lfo and coefficient lookup, allpass cascade and mix on
// one shared multiplier, with the output register.
// ----------------------------------------------------------------------------
module pas_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pas_pkg::item_t                    item,
    input  pas_pkg::cfg_t                     cfg,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pas_pkg::SMP_W-1:0]  sample_out
);
    import pas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LFO, S_FBX, S_IDX, S_DIFF, S_MUL, S_UPD, S_MIXA, S_MIXB, S_MIXC
    } state_t;

    state_t                    state_reg;
    logic [31:0]               phase_reg;
    logic signed [SMP_W-1:0]   last_reg;
    logic signed [SMP_W-1:0]   hin_reg  [MAX_STAGES];
    logic signed [SMP_W-1:0]   hout_reg [MAX_STAGES];
    logic signed [SMP_W-1:0]   dry_reg;
    logic signed [SMP_W-1:0]   x_reg;
    logic [16:0]               lfo_reg;
    logic signed [17:0]        coef_reg;
    logic signed [MUL_A_W-1:0] diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic [STAGE_W-1:0]        s_reg;
    logic                      out_valid_reg;
    logic signed [SMP_W-1:0]   out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      out_free;
    logic                      start;
    logic [COEF_TABLE_BITS:0]  idx;
    logic signed [SMP_W-1:0]   x_next;
    logic signed [SMP_W-1:0]   y_next;
    logic signed [SMP_W-1:0]   out_next;
    logic                      last_stage;
    logic signed [ACC_W-1:0]   mix_sum;

    assign out_free   = !out_valid_reg || !out_stall;
    assign start      = (state_reg == S_IDLE) && item.valid && out_free;
    assign pop        = start;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    assign idx = prod_reg[32 -: (COEF_TABLE_BITS + 1)];

    assign x_next = sat24(ACC_W'(dry_reg) + ACC_W'(prod_reg >>> 16));
    assign y_next = sat24(ACC_W'(hin_reg[s_reg]) + ACC_W'(prod_reg >>> 16));
    assign mix_sum = ACC_W'(acc_reg) + ACC_W'(prod_reg);
    assign out_next = sat24(mix_sum >>> 16);
    assign last_stage = ({1'b0, s_reg} == CNT_W'(cfg.stages - CNT_W'(1)));

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_LFO:
            begin
                mul_a = MUL_A_W'(last_reg);
                mul_b = MUL_B_W'({2'b00, cfg.fb});
            end
            S_FBX:
            begin
                mul_a = MUL_A_W'({8'd0, lfo_reg});
                mul_b = MUL_B_W'({1'b0, cfg.depth});
            end
            S_MUL:
            begin
                mul_a = diff_reg;
                mul_b = coef_reg;
            end
            S_MIXA:
            begin
                mul_a = MUL_A_W'(dry_reg);
                mul_b = MUL_B_W'({1'b0, UNITY_Q16 - cfg.mix});
            end
            S_MIXB:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'({1'b0, cfg.mix});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            s_reg         <= '0;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                hin_reg[i]  <= '0;
                hout_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        dry_reg   <= item.sample;
                        state_reg <= S_LFO;
                    end
                end
                S_LFO:
                begin
                    lfo_reg   <= LFO_TABLE[phase_reg[31 -: COEF_TABLE_BITS]];
                    state_reg <= S_FBX;
                end
                S_FBX:
                begin
                    x_reg     <= x_next;
                    state_reg <= S_IDX;
                end
                S_IDX:
                begin
                    coef_reg  <= COEF_TABLE[idx];
                    s_reg     <= '0;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    diff_reg  <= MUL_A_W'(x_reg) - MUL_A_W'(hout_reg[s_reg]);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    hin_reg[s_reg]  <= x_reg;
                    hout_reg[s_reg] <= y_next;
                    x_reg           <= y_next;
                    if (last_stage)
                        state_reg <= S_MIXA;
                    else
                    begin
                        s_reg     <= s_reg + STAGE_W'(1);
                        state_reg <= S_DIFF;
                    end
                end
                S_MIXA:
                begin
                    last_reg  <= x_reg;
                    state_reg <= S_MIXB;
                end
                S_MIXB:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_MIXC;
                end
                S_MIXC:
                begin
                    out_reg       <= out_next;
                    out_valid_reg <= 1'b1;
                    phase_reg     <= phase_reg + 32'(cfg.phase_step);
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
